FILE: hw/rtl/l2q16c_pkg.sv
// Package for the Q15.16 base-two logarithm pipeline.
// Holds the polynomial coefficients, field widths and the zero sentinel.
// No dependencies.
`default_nettype none

package l2q16c_pkg;

   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned RESULT_W = 31;
   localparam int unsigned IDX_W    = 6;
   localparam int unsigned FRAC_W   = 16;

   localparam logic        [13:0] COEF_C = 14'd10249;
   localparam logic signed [16:0] COEF_B = -17'sd37831;
   localparam logic signed [17:0] COEF_A = 18'sd93118;

   // -2^30 seen in 31 bits
   localparam logic [RESULT_W-1:0] ZERO_SENTINEL = 31'h4000_0000;

endpackage

`default_nettype wire

FILE: hw/rtl/log2_q16_cubic.sv
// log2_q16_cubic: six-stage pipeline computing log2 of a 64-bit unsigned
// value in signed Q15.16 (leading-one index plus a cubic on the fraction).
// Depends on l2q16c_pkg.
//
// Usage:
//   Input channel req_valid / req_stall / req_value; a transfer happens at a
//   rising edge with req_valid high and req_stall low.
//   Result channel rsp_valid / rsp_stall / rsp_log_result, same rule.
//   Exactly one result per input, in order.
//   An input transfer is registered through every stage in order before
//   rsp_valid rises with its result.
//   Throughput: one transfer per cycle while rsp_stall is low; the stages are
//   leading-one detect, normalizing shift, three multiply stages, final add.
//   When rsp_stall holds the result, the last stage holds and earlier
//   stages keep moving into empty slots; req_stall rises only once every
//   stage is occupied.
//   A zero input yields -2^30 (pattern 0x40000000 in 31 bits).
//   Reset (synchronous, active high) empties the pipeline; no result is
//   pending afterwards.
`default_nettype none

module log2_q16_cubic (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [l2q16c_pkg::VALUE_W-1:0]      req_value,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic signed [l2q16c_pkg::RESULT_W-1:0] rsp_log_result
);
   import l2q16c_pkg::*;

   localparam int unsigned STAGES = 6;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] ready;

   // stage 1: leading-one detect
   logic [VALUE_W-1:0] s1_value_ff;
   logic [IDX_W-1:0]   s1_idx_ff, s1_idx_in;
   logic               s1_zero_ff;
   // stage 2: normalize
   logic [FRAC_W-1:0]  s2_x_ff;
   logic [IDX_W-1:0]   s2_idx_ff;
   logic               s2_zero_ff;
   logic [VALUE_W-1:0] s2_norm;
   // stage 3: first multiply
   logic [FRAC_W-1:0]        s3_x_ff;
   logic [IDX_W-1:0]         s3_idx_ff;
   logic                     s3_zero_ff;
   logic signed [16:0]       s3_t1_ff, s3_t1_in;
   logic [29:0]              s3_prod;
   // stage 4: second multiply
   logic [FRAC_W-1:0]        s4_x_ff;
   logic [IDX_W-1:0]         s4_idx_ff;
   logic                     s4_zero_ff;
   logic signed [17:0]       s4_t2_ff, s4_t2_in;
   logic signed [33:0]       s4_prod;
   // stage 5: third multiply
   logic [IDX_W-1:0]         s5_idx_ff;
   logic                     s5_zero_ff;
   logic [16:0]              s5_t3_ff;
   logic [32:0]              s5_prod;
   // stage 6: output
   logic [RESULT_W-1:0]      s6_result_ff, s6_result_in;
   logic [21:0]              s6_sum;

   always_comb begin
      ready[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign req_stall = !ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      s1_idx_in = '0;
      for (int i = 0; i < VALUE_W; i++) begin
         if (req_value[i]) begin
            s1_idx_in = IDX_W'(i);
         end
      end
   end

   assign s2_norm = s1_value_ff << (IDX_W'(VALUE_W - 1) - s1_idx_ff);

   assign s3_prod  = s2_x_ff * COEF_C;
   assign s3_t1_in = $signed({3'b000, s3_prod[29:16]}) + COEF_B;

   assign s4_prod  = $signed({1'b0, s3_x_ff}) * s3_t1_ff;
   assign s4_t2_in = $signed(s4_prod[33:16]) + COEF_A;

   assign s5_prod  = s4_x_ff * s4_t2_ff[16:0];

   assign s6_sum       = {s5_idx_ff, 16'h0000} + {5'b00000, s5_t3_ff};
   assign s6_result_in = s5_zero_ff ? ZERO_SENTINEL
                                    : {{(RESULT_W - 22){1'b0}}, s6_sum};

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         s1_value_ff <= req_value;
         s1_idx_ff   <= s1_idx_in;
         s1_zero_ff  <= (req_value == '0);
      end
      if (ready[1]) begin
         s2_x_ff    <= s2_norm[VALUE_W-2 -: FRAC_W];
         s2_idx_ff  <= s1_idx_ff;
         s2_zero_ff <= s1_zero_ff;
      end
      if (ready[2]) begin
         s3_x_ff    <= s2_x_ff;
         s3_idx_ff  <= s2_idx_ff;
         s3_zero_ff <= s2_zero_ff;
         s3_t1_ff   <= s3_t1_in;
      end
      if (ready[3]) begin
         s4_x_ff    <= s3_x_ff;
         s4_idx_ff  <= s3_idx_ff;
         s4_zero_ff <= s3_zero_ff;
         s4_t2_ff   <= s4_t2_in;
      end
      if (ready[4]) begin
         s5_idx_ff  <= s4_idx_ff;
         s5_zero_ff <= s4_zero_ff;
         s5_t3_ff   <= s5_prod[32:16];
      end
      if (ready[5]) begin
         s6_result_ff <= s6_result_in;
      end
   end

   assign rsp_valid      = valid_ff[STAGES-1];
   assign rsp_log_result = $signed(s6_result_ff);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pipeline not empty after reset");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (valid_ff == {STAGES{1'b1}}))
      else $error("input stalled with an empty stage");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && !ready[1] |=> valid_ff[0])
      else $error("stage 1 item lost while blocked");

   a_t2_positive: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> !s4_t2_ff[17])
      else $error("second Horner term negative");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_log_result[30] |-> (rsp_log_result[29:22] == 8'h00))
      else $error("nonzero result out of range");

endmodule

`default_nettype wire

FILE: verif/log2_q16_cubic_test.sv
// Self-checking testbench for log2_q16_cubic: an in-order predictor of the Q15.16
// log2 against every result transfer, under directed, random and backpressure stimulus.
// Depends on l2q16c_pkg and log2_q16_cubic.
`default_nettype none

module log2_q16_cubic_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW = l2q16c_pkg::VALUE_W;
   localparam int RW = l2q16c_pkg::RESULT_W;
   localparam longint POLY_A = 93118;
   localparam longint POLY_B = -37831;
   localparam longint POLY_C = 10249;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_CYCLES = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [VW-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [RW-1:0] rsp_log_result;

   logic signed [RW-1:0] pending_logs[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int hold_ack = 0;
   int hold_left = 0;

   log2_q16_cubic uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_log_result(rsp_log_result)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic signed [RW-1:0] log2_fixed(input logic [VW-1:0] v);
      int idx;
      logic [VW-1:0] norm;
      longint frac;
      longint acc;
      if (v == '0) begin
         return l2q16c_pkg::ZERO_SENTINEL;
      end
      idx = VW - 1;
      while (!v[idx]) idx--;
      norm = (idx >= 16) ? (v >> (idx - 16)) : (v << (16 - idx));
      frac = longint'(norm[15:0]);
      acc = ((frac * POLY_C) >>> 16) + POLY_B;
      acc = ((frac * acc) >>> 16) + POLY_A;
      acc = (frac * acc) >>> 16;
      return RW'(longint'(idx) * 65536 + acc);
   endfunction

   function automatic logic [VW-1:0] rand_operand();
      int pick;
      int n;
      logic [VW-1:0] wide;
      pick = $urandom_range(99);
      wide = {$urandom, $urandom};
      n = $urandom_range(VW - 1);
      if (pick < 4) return '0;
      if (pick < 24) return wide;
      if (pick < 34) return {{(VW-1){1'b0}}, 1'b1} << n;
      return (wide >> (VW - 1 - n)) | ({{(VW-1){1'b0}}, 1'b1} << n);
   endfunction

   task automatic send_value(input logic [VW-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_value <= {$urandom, $urandom};
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_logs.push_back(log2_fixed(v));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_logs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [VW-1:0] vals[$];
      send_idle_pct = 0;
      stall_pct = 0;
      vals = '{64'd0, 64'd1, 64'd2, 64'd3, 64'hFFFF_FFFF_FFFF_FFFF,
               64'h8000_0000_0000_0000, 64'h0000_0000_0001_0000,
               64'h0000_0000_0000_8000, 64'h0000_0000_0000_FFFF,
               64'h0000_0000_0001_FFFF, 64'h0000_0000_0001_0001,
               64'hFFFF_8000_0000_0000, 64'h8000_8000_0000_0000,
               64'h0000_0000_8000_0000, 64'h0000_0001_0000_0000,
               64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
               64'h0000_0000_0000_0005, 64'h0000_0000_0002_0000};
      foreach (vals[i]) send_value(vals[i]);
      wait_drained();
   endtask

   task automatic test_random(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
      repeat (count) send_value(rand_operand());
      wait_drained();
   endtask

   // receiver holds off long enough for the pipeline to fill and stall the sender
   task automatic test_fill_stall();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_req++;
      repeat (30) send_value(rand_operand());
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_ack != hold_req) begin
         hold_ack <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      logic signed [RW-1:0] exp_log;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_logs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transfer: log_result %0d", rsp_log_result);
         end else begin
            exp_log = pending_logs.pop_front();
            if (rsp_log_result !== exp_log) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("log_result mismatch: expected %0d actual %0d",
                           exp_log, rsp_log_result);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("log2_q16_cubic_test failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(225, 0, 0);
      test_random(225, 52, 0);
      test_random(225, 0, 52);
      test_random(225, 10, 10);
      test_fill_stall();
      wait_drained();
      if (mismatch_count == 0 && pending_logs.size() == 0) begin
         $display("log2_q16_cubic_test passed");
      end else begin
         $display("log2_q16_cubic_test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
